[hdl/span_buffer_row_insert_assert.svh]
// Assertion macros for the span buffer checker file.
// Depends on nothing. Each macro expands to one labeled concurrent assertion.
`ifndef SPAN_BUFFER_ROW_INSERT_ASSERT_SVH
`define SPAN_BUFFER_ROW_INSERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBRI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBRI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sbri_pkg.sv]
// Shared types and constants of the span buffer row insert block.
// Depends on nothing; used by the row lanes, the top level and the checker.
package sbri_pkg;

  // Default geometry of the buffer.
  localparam int ROW_WIDTH_DEF      = 640;
  localparam int NUM_ROWS_DEF       = 480;
  localparam int MAX_BOUNDARIES_DEF = 24;

  // Colour code that marks an uncovered run.
  localparam logic [15:0] EMPTY_COLOUR = 16'hFFFF;

  // Action codes of an input beat.
  typedef enum logic [1:0] {
    ACT_FRAME  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Write controls of the row lanes.
  typedef struct packed {
    logic load;
    logic remove;
  } lane_ctl_t;

endpackage

[hdl/span_buffer_row_insert.sv]
// Top level of the double-buffered span buffer with row insertion.
// Depends on sbri_pkg and sbri_row_lanes.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------------
//  in      | in_valid_i / in_stall_o | action, buffer, row, span_start/end, colour,
//          |                         | entry_index
//  out     | out_valid_o/out_stall_i | boundary_x/colour, row_count, span_dropped,
//          |                         | merge_events, rows_merged
//
// One beat at a time. A read fetches the row count, then the boundary entry.
// A begin frame clears the row counts of its buffer and the dirty marks. An insert
// loads and writes back the row in the boundary memory, one entry per cycle.
// After reset the row count and dirty memories are cleared, with in_stall_o
// high. A result waits in the output register while the next beat is taken;
// the finished beat holds only until that register frees.
module span_buffer_row_insert #(
  parameter int ROW_WIDTH      = sbri_pkg::ROW_WIDTH_DEF,
  parameter int NUM_ROWS       = sbri_pkg::NUM_ROWS_DEF,
  parameter int MAX_BOUNDARIES = sbri_pkg::MAX_BOUNDARIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic               buffer_i,
  input  logic [8:0]         row_i,
  input  logic signed [13:0] span_start_i,
  input  logic signed [13:0] span_end_i,
  input  logic [15:0]        colour_i,
  input  logic [4:0]         entry_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         boundary_x_o,
  output logic [15:0]        boundary_colour_o,
  output logic [4:0]         row_count_o,
  output logic               span_dropped_o,
  output logic [31:0]        merge_events_o,
  output logic [8:0]         rows_merged_o
);
  import sbri_pkg::*;

  localparam int XW   = $clog2(ROW_WIDTH + 1);
  localparam int CW   = $clog2(MAX_BOUNDARIES + 1);
  localparam int IW   = $clog2(MAX_BOUNDARIES);
  localparam int RIW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CAW  = $clog2(2 * NUM_ROWS);
  localparam int AW   = $clog2(2 * NUM_ROWS * MAX_BOUNDARIES);
  localparam int SW   = $clog2(2 * NUM_ROWS + 1);
  localparam int CNT_DEPTH = 2 * NUM_ROWS;
  localparam int BND_DEPTH = 2 * NUM_ROWS * MAX_BOUNDARIES;
  localparam logic signed [13:0] ROW_WIDTH_S = 14'(ROW_WIDTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_COUNT  = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_WRBACK = 3'd4;
  localparam logic [2:0] ST_RDBND  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;
  localparam logic [2:0] ST_CLEAR  = 3'd7;

  // Memories.
  logic [CW-1:0]    cnt_mem [CNT_DEPTH];
  logic             dty_mem [NUM_ROWS];
  logic [XW+15:0]   bnd_mem [BND_DEPTH];
  logic [CW-1:0]    cnt_rdata_q;
  logic             dty_rdata_q;
  logic [XW+15:0]   bnd_rdata_q;

  // Control state.
  logic [2:0]       state_q, state_d;
  logic             out_valid_q;
  logic [31:0]      merge_ctr_q;
  logic [8:0]       total_q;
  logic [SW-1:0]    clr_s_q;
  logic             clr_all_q;
  logic [CAW-1:0]   clr_base_q;

  // Beat and row registers.
  action_e          act_q;
  logic             row_ok_q, span_ok_q;
  logic [RIW-1:0]   row_ix_q;
  logic [CAW-1:0]   caddr_q;
  logic [AW-1:0]    base_q;
  logic [XW-1:0]    a_q, b_q;
  logic [15:0]      colour_q;
  logic [4:0]       idx_q;
  logic             dirty_q;
  logic [CW-1:0]    n_q, iss_q;
  logic             ld_v_q;
  logic [IW-1:0]    ld_k_q;
  logic [CW-1:0]    i0_q, i1_q;
  logic [15:0]      after_q;
  logic             bex_q, have_q;
  logic [XW-1:0]    best_q, vic_x_q, prev_x_q;
  logic [IW-1:0]    vic_q;
  logic [15:0]      vic_pc_q, prev_c_q, prev2_c_q;
  logic             merged_q, ins_q;
  logic [CW-1:0]    lo_q, wb_j_q, wb_end_q;
  logic             drop_q;
  logic [CW-1:0]    res_cnt_q;
  logic [XW-1:0]    res_x_q;
  logic [15:0]      res_c_q;

  // Output register.
  logic [9:0]       bx_q;
  logic [15:0]      bc_q;
  logic [4:0]       cnt_q;
  logic             drp_q;
  logic [31:0]      mev_q;
  logic [8:0]       rmg_q;

  // Combinational.
  logic             acc, out_free;
  logic signed [13:0] a_cl, b_cl;
  logic [RIW-1:0]   row_ix_acc;
  logic [CAW-1:0]   caddr_acc;
  logic             iss_go, go_load, go_read;
  logic [CW:0]      need_w, newn_w, src_w, wb_lo_w;
  logic             fits, ovf_first, wb_last, clr_last;
  logic [SW-1:0]    clr_lim;
  logic [XW-1:0]    ld_x, ld_w, lane_x, wb_x;
  logic [15:0]      ld_c, lane_c, wb_c;
  lane_ctl_t        lane_ctl;
  logic [IW-1:0]    lane_widx;
  logic             cnt_we, dty_we, dty_wd, bnd_we;
  logic [CAW-1:0]   cnt_wa;
  logic [CW-1:0]    cnt_wd;
  logic [RIW-1:0]   dty_wa;
  logic [AW-1:0]    bnd_wa, bnd_ra;

  assign acc        = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Clamp the span and form the row addresses of an incoming beat.
  assign a_cl       = span_start_i[13] ? '0 : span_start_i;
  assign b_cl       = (span_end_i > ROW_WIDTH_S) ? ROW_WIDTH_S : span_end_i;
  assign row_ix_acc = RIW'(row_i);
  assign caddr_acc  = buffer_i ? CAW'(NUM_ROWS) + CAW'(row_ix_acc) : CAW'(row_ix_acc);

  // Boundary arriving from memory during the row load.
  assign ld_x = bnd_rdata_q[XW+15:16];
  assign ld_c = bnd_rdata_q[15:0];
  assign ld_w = ld_x - prev_x_q;

  assign iss_go  = (state_q == ST_LOAD) && (iss_q < n_q);
  assign go_load = (act_q == ACT_INSERT) && row_ok_q && span_ok_q;
  assign go_read = (act_q == ACT_READ) && row_ok_q && (int'(idx_q) < int'(cnt_rdata_q));

  // Fit test of the span against the row as it stands.
  assign need_w    = bex_q ? (CW+1)'(1) : (CW+1)'(2);
  assign newn_w    = {1'b0, n_q} - {1'b0, i1_q} + {1'b0, i0_q} + need_w;
  assign fits      = newn_w <= (CW+1)'(MAX_BOUNDARIES);
  assign ovf_first = (state_q == ST_DECIDE) && !fits && !merged_q;
  assign wb_lo_w   = (lo_q < i0_q) ? {1'b0, lo_q} : {1'b0, i0_q};

  // Write-back source: before the span the row as is, after it shifted.
  always_comb begin
    src_w = {1'b0, wb_j_q};
    if (ins_q && ({1'b0, wb_j_q} >= {1'b0, i0_q} + need_w)) begin
      src_w = {1'b0, wb_j_q} + {1'b0, i1_q} - {1'b0, i0_q} - need_w;
    end
    wb_x = lane_x;
    wb_c = lane_c;
    if (ins_q && (wb_j_q == i0_q)) begin
      wb_x = a_q;
      wb_c = colour_q;
    end else if (ins_q && !bex_q && (wb_j_q == i0_q + CW'(1))) begin
      wb_x = b_q;
      wb_c = after_q;
    end
  end
  assign wb_last = ({1'b0, wb_j_q} + (CW+1)'(1)) >= {1'b0, wb_end_q};

  assign clr_lim  = clr_all_q ? SW'(2 * NUM_ROWS) : SW'(NUM_ROWS);
  assign clr_last = (clr_s_q + SW'(1)) == clr_lim;

  // Row lanes hold the working copy of the addressed row.
  always_comb begin
    lane_ctl.load   = (state_q == ST_LOAD) && ld_v_q;
    lane_ctl.remove = ovf_first && (n_q >= CW'(3));
    lane_widx       = lane_ctl.load ? ld_k_q : vic_q;
  end

  sbri_row_lanes #(
    .MAX_BOUNDARIES(MAX_BOUNDARIES),
    .XW            (XW)
  ) u_lanes (
    .clk_i   (clk_i),
    .ctl_i   (lane_ctl),
    .wr_idx_i(lane_widx),
    .wr_x_i  (ld_x),
    .wr_c_i  (ld_c),
    .rd_idx_i(IW'(src_w)),
    .rd_x_o  (lane_x),
    .rd_c_o  (lane_c)
  );

  // Memory port controls.
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = caddr_q;
    cnt_wd = '0;
    dty_we = 1'b0;
    dty_wa = row_ix_q;
    dty_wd = 1'b0;
    if (state_q == ST_CLEAR) begin
      cnt_we = 1'b1;
      cnt_wa = clr_base_q + CAW'(clr_s_q);
      dty_we = clr_s_q < SW'(NUM_ROWS);
      dty_wa = RIW'(clr_s_q);
    end else if (state_q == ST_DECIDE) begin
      cnt_we = fits || merged_q;
      cnt_wd = fits ? CW'(newn_w) : n_q;
      dty_we = ovf_first && !dirty_q;
      dty_wd = 1'b1;
    end
  end
  assign bnd_we = (state_q == ST_WRBACK) && (wb_j_q < wb_end_q);
  assign bnd_wa = base_q + AW'(wb_j_q);
  assign bnd_ra = base_q + ((state_q == ST_LOAD) ? AW'(iss_q) : AW'(idx_q));

  // Row count memory.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rdata_q <= cnt_mem[caddr_acc];
  end

  // Dirty mark memory.
  always_ff @(posedge clk_i) begin
    if (dty_we) begin
      dty_mem[dty_wa] <= dty_wd;
    end
    dty_rdata_q <= dty_mem[row_ix_acc];
  end

  // Boundary memory.
  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      bnd_mem[bnd_wa] <= {wb_x, wb_c};
    end
    bnd_rdata_q <= bnd_mem[bnd_ra];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = (action_i == ACT_FRAME) ? ST_CLEAR : ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (go_load) begin
          state_d = ST_LOAD;
        end else if (go_read) begin
          state_d = ST_RDBND;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_LOAD: begin
        if (!iss_go && !ld_v_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (fits || merged_q) begin
          state_d = ST_WRBACK;
        end else if (n_q < CW'(3)) begin
          state_d = ST_FINISH;
        end
      end
      ST_WRBACK: begin
        if (wb_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_RDBND:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = clr_all_q ? ST_IDLE : ST_FINISH;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control registers, totals and the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      merge_ctr_q <= '0;
      total_q     <= '0;
      clr_s_q     <= '0;
      clr_all_q   <= 1'b1;
      clr_base_q  <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ovf_first) begin
        merge_ctr_q <= merge_ctr_q + 32'd1;
        if (!dirty_q) begin
          total_q <= total_q + 9'd1;
        end
      end
      if (acc && (action_i == ACT_FRAME)) begin
        total_q    <= '0;
        clr_s_q    <= '0;
        clr_base_q <= buffer_i ? CAW'(NUM_ROWS) : '0;
      end else if (state_q == ST_CLEAR) begin
        clr_s_q <= clr_s_q + SW'(1);
        if (clr_last) begin
          clr_all_q <= 1'b0;
        end
      end
    end
  end

  // Datapath registers of the beat in flight.
  always_ff @(posedge clk_i) begin
    ld_v_q <= iss_go;
    ld_k_q <= IW'(iss_q);
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          act_q     <= action_e'(action_i);
          row_ok_q  <= 32'(row_i) < NUM_ROWS;
          row_ix_q  <= row_ix_acc;
          caddr_q   <= caddr_acc;
          base_q    <= AW'(caddr_acc) * AW'(MAX_BOUNDARIES);
          a_q       <= XW'(a_cl);
          b_q       <= XW'(b_cl);
          span_ok_q <= a_cl < b_cl;
          colour_q  <= colour_i;
          idx_q     <= entry_index_i;
          res_x_q   <= '0;
          res_c_q   <= EMPTY_COLOUR;
          res_cnt_q <= '0;
          drop_q    <= 1'b0;
        end
      end
      ST_COUNT: begin
        n_q       <= cnt_rdata_q;
        res_cnt_q <= row_ok_q ? cnt_rdata_q : '0;
        dirty_q   <= dty_rdata_q;
        iss_q     <= '0;
        i0_q      <= '0;
        i1_q      <= '0;
        after_q   <= EMPTY_COLOUR;
        bex_q     <= 1'b0;
        have_q    <= 1'b0;
        merged_q  <= 1'b0;
      end
      ST_LOAD: begin
        if (iss_go) begin
          iss_q <= iss_q + CW'(1);
        end
        // Position counts, the colour before b and the narrowest inner run.
        if (ld_v_q) begin
          if (ld_x < a_q) begin
            i0_q <= i0_q + CW'(1);
          end
          if (ld_x < b_q) begin
            i1_q    <= i1_q + CW'(1);
            after_q <= ld_c;
          end
          if (ld_x == b_q) begin
            bex_q <= 1'b1;
          end
          if (ld_k_q >= IW'(2)) begin
            if (!have_q || (ld_w < best_q)) begin
              have_q   <= 1'b1;
              best_q   <= ld_w;
              vic_q    <= ld_k_q - IW'(1);
              vic_x_q  <= prev_x_q;
              vic_pc_q <= prev2_c_q;
            end
          end
          prev_x_q  <= ld_x;
          prev_c_q  <= ld_c;
          prev2_c_q <= prev_c_q;
        end
      end
      ST_DECIDE: begin
        if (fits) begin
          ins_q     <= 1'b1;
          wb_j_q    <= merged_q ? CW'(wb_lo_w) : i0_q;
          wb_end_q  <= CW'(newn_w);
          res_cnt_q <= CW'(newn_w);
        end else if (merged_q) begin
          // Still full after the merge: keep the merge, drop the span.
          ins_q     <= 1'b0;
          wb_j_q    <= lo_q;
          wb_end_q  <= n_q;
          res_cnt_q <= n_q;
          drop_q    <= 1'b1;
        end else if (n_q < CW'(3)) begin
          drop_q <= 1'b1;
        end else begin
          // Remove the victim and adjust the search results to match.
          merged_q <= 1'b1;
          lo_q     <= CW'(vic_q);
          n_q      <= n_q - CW'(1);
          if (vic_x_q < a_q) begin
            i0_q <= i0_q - CW'(1);
          end
          if (vic_x_q < b_q) begin
            i1_q <= i1_q - CW'(1);
          end
          if (vic_x_q == b_q) begin
            bex_q <= 1'b0;
          end
          if ((CW'(vic_q) + CW'(1)) == i1_q) begin
            after_q <= vic_pc_q;
          end
        end
      end
      ST_WRBACK: begin
        wb_j_q <= wb_j_q + CW'(1);
      end
      ST_RDBND: begin
        res_x_q <= ld_x;
        res_c_q <= ld_c;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      bx_q  <= 10'(res_x_q);
      bc_q  <= res_c_q;
      cnt_q <= 5'(res_cnt_q);
      drp_q <= drop_q;
      mev_q <= merge_ctr_q;
      rmg_q <= total_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign boundary_x_o      = bx_q;
  assign boundary_colour_o = bc_q;
  assign row_count_o       = cnt_q;
  assign span_dropped_o    = drp_q;
  assign merge_events_o    = mev_q;
  assign rows_merged_o     = rmg_q;

endmodule

[hdl/sbri_row_lanes.sv]
// Working copy of one row: a lane per boundary, loaded one entry a cycle,
// with a removal that shifts the later lanes down. Depends on sbri_pkg.
module sbri_row_lanes #(
  parameter int MAX_BOUNDARIES = sbri_pkg::MAX_BOUNDARIES_DEF,
  parameter int XW             = 10
) (
  input  logic                              clk_i,
  input  sbri_pkg::lane_ctl_t               ctl_i,
  input  logic [$clog2(MAX_BOUNDARIES)-1:0] wr_idx_i,
  input  logic [XW-1:0]                     wr_x_i,
  input  logic [15:0]                       wr_c_i,
  input  logic [$clog2(MAX_BOUNDARIES)-1:0] rd_idx_i,
  output logic [XW-1:0]                     rd_x_o,
  output logic [15:0]                       rd_c_o
);
  import sbri_pkg::*;

  logic [XW-1:0] x_q [MAX_BOUNDARIES];
  logic [15:0]   c_q [MAX_BOUNDARIES];

  // Load one entry, or drop the entry at wr_idx_i and pull the rest down.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q[wr_idx_i] <= wr_x_i;
      c_q[wr_idx_i] <= wr_c_i;
    end else if (ctl_i.remove) begin
      for (int j = 0; j < MAX_BOUNDARIES - 1; j++) begin
        if (j >= int'(wr_idx_i)) begin
          x_q[j] <= x_q[j+1];
          c_q[j] <= c_q[j+1];
        end
      end
    end
  end

  assign rd_x_o = x_q[rd_idx_i];
  assign rd_c_o = c_q[rd_idx_i];

endmodule

[hdl/sbri_checker.sv]
// Port-level checks of the span buffer row insert block, bound to the top.
// Depends on sbri_pkg and span_buffer_row_insert_assert.svh.
`include "span_buffer_row_insert_assert.svh"

module sbri_checker #(
  parameter int NUM_ROWS = sbri_pkg::NUM_ROWS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [9:0]         boundary_x_o,
  input logic [15:0]        boundary_colour_o,
  input logic [4:0]         row_count_o,
  input logic               span_dropped_o,
  input logic [31:0]        merge_events_o,
  input logic [8:0]         rows_merged_o
);
  import sbri_pkg::*;

  // A stalled result beat stays put.
  `SBRI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(boundary_x_o) && $stable(row_count_o) && $stable(merge_events_o), "stalled result beat changed")

  // One beat at a time: taking a beat makes the block busy.
  `SBRI_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken while a beat is in flight")

  // A dropped span reports no boundary.
  `SBRI_ASSERT_IMP(a_drop_no_bnd, clk_i, rst_ni, out_valid_o && span_dropped_o, boundary_x_o == 10'd0 && boundary_colour_o == EMPTY_COLOUR, "dropped span carries a boundary")

  // A drop always follows a merge that marked its row dirty.
  `SBRI_ASSERT_IMP(a_drop_dirty, clk_i, rst_ni, (NUM_ROWS < 512) && out_valid_o && span_dropped_o, rows_merged_o != 9'd0, "drop without a merged row")

endmodule

bind span_buffer_row_insert sbri_checker #(.NUM_ROWS(NUM_ROWS)) u_sbri_checker (.*);

[tb/tb.sv]
// Testbench for span_buffer_row_insert: drives begin-frame, insert and read beats
// through the valid/stall handshake and checks every result against a predictor.
// Depends on sbri_pkg and the span_buffer_row_insert RTL.
`timescale 1ns / 100ps

module tb;
  import sbri_pkg::*;

  localparam int RW = 640;
  localparam int NR = 480;
  localparam int MB = 24;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i = '0;
  logic               buffer_i = 1'b0;
  logic [8:0]         row_i = '0;
  logic signed [13:0] span_start_i = '0;
  logic signed [13:0] span_end_i = '0;
  logic [15:0]        colour_i = '0;
  logic [4:0]         entry_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [9:0]         boundary_x_o;
  logic [15:0]        boundary_colour_o;
  logic [4:0]         row_count_o;
  logic               span_dropped_o;
  logic [31:0]        merge_events_o;
  logic [8:0]         rows_merged_o;

  span_buffer_row_insert DUT (.*);

  // Result of one beat.
  typedef struct packed {
    logic [9:0]  bx;
    logic [15:0] bc;
    logic [4:0]  cnt;
    logic        drop;
    logic [31:0] merges;
    logic [8:0]  rmerged;
  } span_result_t;

  span_result_t pending_results[$];

  // Predictor state.
  logic [15:0] row_x[2][NR][MB];
  logic [15:0] row_c[2][NR][MB];
  int          row_n[2][NR];
  bit          dirty[NR];
  logic [8:0]  dirty_total = '0;
  logic [31:0] merge_total = '0;

  int  n_errors = 0;
  int  n_results = 0;
  int  n_items = 0;
  int  n_drops = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  hold_cycles = 0;

  // Place [a,b) with colour c into one row; returns new count or -1.
  function automatic int place_span(int bf, int r, int n, int a, int b, logic [15:0] c);
    int i0, i1, need, newn, k;
    logic [15:0] after;
    bit b_hit;
    logic [15:0] tx[MB + 2];
    logic [15:0] tc[MB + 2];
    i0 = 0;
    while (i0 < n && int'(row_x[bf][r][i0]) < a) i0++;
    i1 = i0;
    while (i1 < n && int'(row_x[bf][r][i1]) < b) i1++;
    after = (i1 > 0) ? row_c[bf][r][i1 - 1] : EMPTY_COLOUR;
    b_hit = (i1 < n && int'(row_x[bf][r][i1]) == b);
    need = b_hit ? 1 : 2;
    newn = n - (i1 - i0) + need;
    if (newn > MB) return -1;
    for (k = 0; k < i0; k++) begin
      tx[k] = row_x[bf][r][k];
      tc[k] = row_c[bf][r][k];
    end
    tx[i0] = a[15:0];
    tc[i0] = c;
    if (!b_hit) begin
      tx[i0 + 1] = b[15:0];
      tc[i0 + 1] = after;
    end
    for (k = i1; k < n; k++) begin
      tx[i0 + need + k - i1] = row_x[bf][r][k];
      tc[i0 + need + k - i1] = row_c[bf][r][k];
    end
    for (k = 0; k < newn; k++) begin
      row_x[bf][r][k] = tx[k];
      row_c[bf][r][k] = tc[k];
    end
    return newn;
  endfunction

  // Insert with overflow merge; returns 1 when the span is dropped.
  function automatic bit add_span_to_row(int bf, int r, int a, int b, logic [15:0] c);
    int n, res, victim, best, k, w;
    n = row_n[bf][r];
    victim = 1;
    best = RW + 1;
    if (a < 0) a = 0;
    if (b > RW) b = RW;
    if (a >= b) return 1'b0;
    res = place_span(bf, r, n, a, b, c);
    if (res >= 0) begin
      row_n[bf][r] = res;
      return 1'b0;
    end
    merge_total++;
    if (!dirty[r]) begin
      dirty[r] = 1'b1;
      dirty_total++;
    end
    if (n < 3) return 1'b1;
    for (k = 1; k + 1 < n; k++) begin
      w = int'(row_x[bf][r][k + 1]) - int'(row_x[bf][r][k]);
      if (w < best) begin
        best = w;
        victim = k;
      end
    end
    for (k = victim; k < n - 1; k++) begin
      row_x[bf][r][k] = row_x[bf][r][k + 1];
      row_c[bf][r][k] = row_c[bf][r][k + 1];
    end
    n--;
    row_n[bf][r] = n;
    res = place_span(bf, r, n, a, b, c);
    if (res < 0) return 1'b1;
    row_n[bf][r] = res;
    return 1'b0;
  endfunction

  // Expected result of one beat, updating the predictor state.
  function automatic span_result_t predict_beat(logic [1:0] act, logic bf, logic [8:0] r,
                                                logic signed [13:0] s, logic signed [13:0] e,
                                                logic [15:0] c, logic [4:0] idx);
    span_result_t res;
    bit ok;
    ok = (r < NR);
    res = '0;
    res.bc = EMPTY_COLOUR;
    case (action_e'(act))
      ACT_FRAME: begin
        for (int i = 0; i < NR; i++) begin
          row_n[bf][i] = 0;
          dirty[i] = 1'b0;
        end
        dirty_total = '0;
      end
      ACT_INSERT: begin
        if (ok) res.drop = add_span_to_row(bf, r, int'(s), int'(e), c);
      end
      ACT_READ: begin
        if (ok && idx < row_n[bf][r]) begin
          res.bx = row_x[bf][r][idx][9:0];
          res.bc = row_c[bf][r][idx];
        end
      end
      default: ;
    endcase
    if (ok) res.cnt = row_n[bf][r][4:0];
    res.merges = merge_total;
    res.rmerged = dirty_total;
    return res;
  endfunction

  // Send one beat, with random idle cycles ahead of it while send_idle is set.
  task automatic send_beat(logic [1:0] act, logic bf, logic [8:0] r, int s, int e,
                           logic [15:0] c, logic [4:0] idx);
    while (send_idle && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    buffer_i <= bf;
    row_i <= r;
    span_start_i <= s[13:0];
    span_end_i <= e[13:0];
    colour_i <= c;
    entry_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_beat(act, bf, r, s[13:0], e[13:0], c, idx));
    if (act == ACT_INSERT || act == ACT_READ) n_items++;
    // The block is busy in the cycle after a taken beat.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= recv_idle && ($urandom_range(99) < 25);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    span_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no beat pending");
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_results++;
        if (span_dropped_o) n_drops++;
        if (boundary_x_o !== exp_r.bx) begin
          $error("boundary_x exp %0d got %0d", exp_r.bx, boundary_x_o); n_errors++;
        end
        if (boundary_colour_o !== exp_r.bc) begin
          $error("boundary_colour exp %h got %h", exp_r.bc, boundary_colour_o);
          n_errors++;
        end
        if (row_count_o !== exp_r.cnt) begin
          $error("row_count exp %0d got %0d", exp_r.cnt, row_count_o); n_errors++;
        end
        if (span_dropped_o !== exp_r.drop) begin
          $error("span_dropped exp %0d got %0d", exp_r.drop, span_dropped_o); n_errors++;
        end
        if (merge_events_o !== exp_r.merges) begin
          $error("merge_events exp %0d got %0d", exp_r.merges, merge_events_o); n_errors++;
        end
        if (rows_merged_o !== exp_r.rmerged) begin
          $error("rows_merged exp %0d got %0d", exp_r.rmerged, rows_merged_o); n_errors++;
        end
      end
    end
  end

  // Reads every boundary of a row plus one past the end.
  task automatic read_row(logic bf, int r);
    for (int i = 0; i <= row_n[bf][r] && i < 32; i++)
      send_beat(ACT_READ, bf, 9'(r), 0, 0, 0, 5'(i));
  endtask

  // Directed: field extremes, out-of-range rows, empty spans, nop and reads.
  task automatic test_directed();
    send_beat(ACT_FRAME, 1'b0, 0, 0, 0, 0, 0);
    send_beat(ACT_FRAME, 1'b1, 0, 0, 0, 0, 0);
    send_beat(ACT_INSERT, 1'b0, 0, -4096, 4096, 16'h1234, 0);
    send_beat(ACT_INSERT, 1'b0, 0, 100, 200, 16'hFFFF, 0);
    send_beat(ACT_INSERT, 1'b0, 0, 300, 300, 16'h0000, 0);
    send_beat(ACT_INSERT, 1'b0, 0, 700, 800, 16'h5555, 0);
    send_beat(ACT_INSERT, 1'b1, 479, -8192, 8191, 16'hAAAA, 31);
    send_beat(ACT_INSERT, 1'b0, 511, 0, 10, 16'h1, 0);
    send_beat(ACT_READ, 1'b0, 480, 0, 0, 0, 0);
    send_beat(ACT_NOP, 1'b1, 511, -1, -1, 16'hFFFF, 31);
    read_row(1'b0, 0);
    send_beat(ACT_READ, 1'b1, 479, 0, 0, 0, 31);
    wait_drained();
  endtask

  // Overflow: narrow spans packed into one row force merges and drops.
  task automatic test_overflow();
    for (int i = 0; i < 30; i++)
      send_beat(ACT_INSERT, 1'b1, 7, i * 20 + 1, i * 20 + 3 + (i % 4), 16'($urandom), 0);
    send_beat(ACT_INSERT, 1'b0, 9, 5, 6, 16'h10, 0);
    for (int i = 0; i < 3; i++)
      send_beat(ACT_INSERT, 1'b0, 9, 2 + i * 4, 4 + i * 4, 16'(i), 0);
    read_row(1'b1, 7);
    send_beat(ACT_FRAME, 1'b1, 0, 0, 0, 0, 0);
    send_beat(ACT_READ, 1'b1, 7, 0, 0, 0, 0);
  endtask

  // Back pressure: long receiver hold while the sender keeps offering beats.
  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 300;
    send_idle = 1'b0;
    for (int i = 0; i < 20; i++)
      send_beat(ACT_INSERT, 1'b0, 3, int'($urandom_range(0, 639)),
                int'($urandom_range(1, 640)), 16'($urandom), 0);
    send_idle = 1'b1;
    wait_drained();
  endtask

  // Random: a few hot rows so rows fill up, mixed with noise.
  task automatic test_random();
    int r, s, e, sel;
    for (int k = 0; k < 650; k++) begin
      if (k == 300) begin
        recv_idle = 1'b0;
        send_idle = 1'b0;
      end
      if (k == 400) begin
        recv_idle = 1'b1;
        send_idle = 1'b1;
      end
      r = ($urandom_range(9) < 8) ? int'($urandom_range(0, 5)) : int'($urandom_range(0, 511));
      sel = int'($urandom_range(99));
      if (sel < 2) send_beat(ACT_FRAME, 1'($urandom), 0, 0, 0, 0, 0);
      else if (sel < 4) send_beat(ACT_NOP, 1'($urandom), 9'($urandom), int'($urandom),
                                  int'($urandom), 16'($urandom), 5'($urandom));
      else if (sel < 30) send_beat(ACT_READ, 1'($urandom), 9'(r), int'($urandom),
                                   int'($urandom), 16'($urandom),
                                   5'($urandom_range(0, 31)));
      else begin
        if ($urandom_range(9) == 0) begin
          s = int'($urandom_range(0, 8191)) - 4096;
          e = int'($urandom_range(0, 8191)) - 4096;
          if ($urandom_range(3) == 0) s = int'($urandom_range(0, 16383)) - 8192;
        end else begin
          s = int'($urandom_range(0, 639));
          e = s + int'($urandom_range(1, 60));
        end
        send_beat(ACT_INSERT, 1'($urandom), 9'(r), s, e, 16'($urandom), 5'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d insert/read beats, %0d results, %0d dropped spans, %0d merges.",
             n_items, n_results, n_drops, merge_total);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

[files.f]
+incdir+hdl
hdl/sbri_pkg.sv
hdl/sbri_row_lanes.sv
hdl/span_buffer_row_insert.sv
hdl/sbri_checker.sv
tb/tb.sv
